[rtl/note_sequence_timer_unit_defines.svh]
// Assertion macros shared by the note sequence timer RTL.
// Include by bare file name; no other dependencies.
`ifndef NOTE_SEQUENCE_TIMER_UNIT_DEFINES_SVH
`define NOTE_SEQUENCE_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define NST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nst_pkg.sv]
// Types and constants for the note sequence timer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

    localparam int OP_W       = 3;
    localparam int TARGET_W   = 6;
    localparam int FREQ_W     = 16;
    localparam int VOL_W      = 9;
    localparam int MS_W       = 16;
    localparam int RATE_W     = 17;
    localparam int LEN_W      = 23;
    localparam int MODE_W     = 2;
    localparam int POS_OUT_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_RATE        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 1'b1;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd32000;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 23'h7FFFFF;

    // ms * rate / 1000 as ((ms * rate) >> 3) / 125 via reciprocal
    localparam int MS_PER_S    = 1000;
    localparam int PROD_W      = MS_W + RATE_W;
    localparam int QUO_W       = PROD_W - 3;
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 31;
    localparam int WIDE_W      = QUO_W + RECIP_W;
    localparam int EST_W       = 24;
    localparam int REM_W       = 31;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / (MS_PER_S / 8);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_FULL);
    localparam logic [REM_W-1:0]   DIV_REST = REM_W'(MS_PER_S / 8);
    localparam logic [PROD_W-1:0]  SAT_PRODUCT =
        PROD_W'((64'd1 << LEN_W) * 64'(MS_PER_S));

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_APPEND = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_PLAY   = 3'd3,
        OP_PAUSE  = 3'd4,
        OP_STOP   = 3'd5,
        OP_JUMP   = 3'd6
    } opcode_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED = 2'd0,
        MODE_PLAYING = 2'd1,
        MODE_PAUSED  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [VOL_W-1:0]  vol;
        logic [MS_W-1:0]   tone_ms;
        logic [MS_W-1:0]   rest_ms;
    } note_entry_t;

    localparam int NOTE_W = $bits(note_entry_t);

    typedef struct packed {
        logic [MS_W-1:0] tone_ms;
        logic [MS_W-1:0] rest_ms;
    } conv_req_t;

    typedef struct packed {
        logic [LEN_W-1:0] tone_len;
        logic [LEN_W-1:0] rest_len;
    } conv_res_t;

endpackage

`default_nettype wire

[rtl/nst_if.sv]
// Valid/ready channel interfaces: command in, status out.
// Depends on nst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nst_cmd_if;
    import nst_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [TARGET_W-1:0] target_note;
    logic [FREQ_W-1:0]   note_freq_hz;
    logic [VOL_W-1:0]    note_volume;
    logic [MS_W-1:0]     tone_ms;
    logic [MS_W-1:0]     rest_ms;

    modport source (
        output valid, opcode, target_note, note_freq_hz, note_volume, tone_ms, rest_ms,
        input  ready
    );

    modport sink (
        input  valid, opcode, target_note, note_freq_hz, note_volume, tone_ms, rest_ms,
        output ready
    );
endinterface

interface nst_stat_if;
    import nst_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 sounding;
    logic                 gate;
    logic [FREQ_W-1:0]    out_freq_hz;
    logic [VOL_W-1:0]     out_volume;
    logic [POS_OUT_W-1:0] position;
    logic [MODE_W-1:0]    play_mode;
    logic                 done_res;
    logic                 rejected;

    modport source (
        output valid, sounding, gate, out_freq_hz, out_volume, position, play_mode,
               done_res, rejected,
        input  ready
    );

    modport sink (
        input  valid, sounding, gate, out_freq_hz, out_volume, position, play_mode,
               done_res, rejected,
        output ready
    );
endinterface

`default_nettype wire

[rtl/nst_ms_conv.sv]
// Three-stage ms-to-samples converter for tone and rest lengths.
// len = min(floor(ms * rate / 1000), 2^23-1). Depends on nst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nst_ms_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flush,
    input  logic                          in_valid,
    input  nst_pkg::conv_req_t            req,
    input  logic [nst_pkg::RATE_W-1:0]    rate,
    output logic                          out_valid,
    output nst_pkg::conv_res_t            res
);
    import nst_pkg::*;

    logic [MS_W-1:0]   ms_lane   [2];
    logic [PROD_W-1:0] prod_reg  [2];
    logic [QUO_W-1:0]  quo_reg   [2];
    logic [WIDE_W-1:0] wide_reg  [2];
    logic              sat_reg   [2];
    logic [EST_W-1:0]  est       [2];
    logic [REM_W-1:0]  rem       [2];
    logic [EST_W-1:0]  est_fix   [2];
    logic [LEN_W-1:0]  len_next  [2];
    logic [LEN_W-1:0]  len_reg   [2];
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;

    always_comb
    begin
        ms_lane[0] = req.tone_ms;
        ms_lane[1] = req.rest_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (flush)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // quotient estimate is exact or one low; one correction step
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            est[i]      = wide_reg[i][WIDE_W-1 -: EST_W];
            rem[i]      = REM_W'(quo_reg[i]) - REM_W'(est[i]) * DIV_REST;
            est_fix[i]  = (rem[i] >= DIV_REST) ? est[i] + EST_W'(1) : est[i];
            len_next[i] = sat_reg[i] ? LEN_MAX : est_fix[i][LEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            prod_reg[i] <= PROD_W'(ms_lane[i]) * PROD_W'(rate);
            quo_reg[i]  <= prod_reg[i][PROD_W-1:3];
            sat_reg[i]  <= prod_reg[i] >= SAT_PRODUCT;
            wide_reg[i] <= WIDE_W'(prod_reg[i][PROD_W-1:3]) * WIDE_W'(RECIP);
            len_reg[i]  <= len_next[i];
        end
    end

    assign out_valid    = v3_reg;
    assign res.tone_len = len_reg[0];
    assign res.rest_len = len_reg[1];

endmodule

`default_nettype wire

[rtl/note_sequence_timer_unit.sv]
// Note sequence timer top level: note table memory, current-note cache, step logic.
// Depends on nst_pkg, nst_if, nst_ms_conv and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "note_sequence_timer_unit_defines.svh"

// Usage:
//   cmd  : one transaction per opcode (tick, append, clear, play, pause, stop, jump).
//   stat : exactly one status transaction per command, in command order.
//   cfg  : write the sample rate (index 0) or loop_enable (index 1) while idle.
// A taken command's status passes through the completion stage and then the
// output register; a command that lands on a note inside the table that needs a
// refill first waits in the completion stage until the refill is done.
// Throughput: one command per cycle while the current note and the sample rate
// stay the same and stat.ready is high.
// The note at the current position is held in a small cache filled from the note
// table by a read plus a three-stage ms-to-samples converter; a command that moves
// the position, an append into the current slot, or a sample-rate write refills it,
// and commands wait for the refill when the position is inside the table.
// Reset: table empty, position 0, stopped, gate low, sample rate 32000, no
// loop. Table contents are not cleared.
// Stall: status is registered; while stat.ready is low one more command can
// complete into the internal stage, then cmd.ready drops.
module note_sequence_timer_unit #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    nst_cmd_if.sink                          cmd,
    nst_stat_if.source                       stat,
    input  logic                             cfg_we,
    input  logic [nst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nst_pkg::*;

    localparam int POS_W  = $clog2(NOTE_DEPTH + 1);
    localparam int ADDR_W = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int CMP_W  = (POS_W > TARGET_W) ? POS_W : TARGET_W;

    logic [NOTE_W-1:0] note_mem [NOTE_DEPTH];

    // architectural state
    logic [POS_W-1:0]  note_total_reg, note_total_next;
    logic [POS_W-1:0]  note_pos_reg, note_pos_next;
    logic [LEN_W-1:0]  sample_counter_reg, sample_counter_next;
    logic [LEN_W-1:0]  tone_len_reg, tone_len_next;
    logic [LEN_W-1:0]  rest_len_reg, rest_len_next;
    logic              resting_reg, resting_next;
    logic              finished_reg, finished_next;
    mode_t             mode_reg, mode_next;
    logic              gate_reg, gate_next;
    logic [RATE_W-1:0] rate_reg;
    logic              loop_reg;

    // current-note cache and its fill path
    logic              cache_valid_reg;
    logic              fetch_busy_reg;
    logic              rd_valid_reg;
    note_entry_t       rd_data_reg;
    logic [FREQ_W-1:0] cache_freq_reg;
    logic [VOL_W-1:0]  cache_vol_reg;
    logic [LEN_W-1:0]  cache_tone_reg;
    logic [LEN_W-1:0]  cache_rest_reg;
    logic              fetch_issue;
    logic              inval;
    conv_req_t         conv_req;
    conv_res_t         conv_res;
    logic              conv_valid;

    // completion stage and output register
    logic              c_valid_reg;
    logic              c_sounding_reg;
    logic              c_gate_reg;
    logic [POS_W-1:0]  c_pos_reg;
    mode_t             c_mode_reg;
    logic              c_done_reg;
    logic              c_rejected_reg;
    logic              c_in_range_reg;
    logic              c_move;
    logic              o_valid_reg;
    logic              o_sounding_reg;
    logic              o_gate_reg;
    logic [FREQ_W-1:0] o_freq_reg;
    logic [VOL_W-1:0]  o_vol_reg;
    logic [POS_W-1:0]  o_pos_reg;
    mode_t             o_mode_reg;
    logic              o_done_reg;
    logic              o_rejected_reg;

    // step logic
    logic              cmd_accept;
    logic              in_range_cur;
    logic              in_range_new;
    logic              sounding;
    logic              rejected;
    logic              advance;
    logic              mem_we;
    logic [POS_W-1:0]  pos_inc;
    logic [CMP_W-1:0]  target_ext;
    logic [CMP_W-1:0]  total_ext;
    note_entry_t       wr_entry;

    assign in_range_cur = note_pos_reg < note_total_reg;
    assign c_move       = c_valid_reg && (cache_valid_reg || !c_in_range_reg)
                          && (!o_valid_reg || stat.ready);
    assign cmd.ready    = (cache_valid_reg || !in_range_cur) && (!c_valid_reg || c_move);
    assign cmd_accept   = cmd.valid && cmd.ready;
    assign pos_inc      = note_pos_reg + POS_W'(1);
    assign target_ext   = CMP_W'(cmd.target_note);
    assign total_ext    = CMP_W'(note_total_reg);

    assign wr_entry.freq    = cmd.note_freq_hz;
    assign wr_entry.vol     = cmd.note_volume;
    assign wr_entry.tone_ms = cmd.tone_ms;
    assign wr_entry.rest_ms = cmd.rest_ms;

    always_comb
    begin
        note_total_next     = note_total_reg;
        note_pos_next       = note_pos_reg;
        sample_counter_next = sample_counter_reg;
        tone_len_next       = tone_len_reg;
        rest_len_next       = rest_len_reg;
        resting_next        = resting_reg;
        finished_next       = finished_reg;
        mode_next           = mode_reg;
        gate_next           = gate_reg;
        sounding            = 1'b0;
        rejected            = 1'b0;
        advance             = 1'b0;
        mem_we              = 1'b0;

        if (cmd_accept)
        begin
            case (cmd.opcode)
                OP_TICK:
                begin
                    if (mode_reg == MODE_PLAYING && note_total_reg != '0)
                    begin
                        if (!finished_reg && in_range_cur)
                        begin
                            if (!resting_reg)
                            begin
                                if (tone_len_reg == '0)
                                begin
                                    tone_len_next = cache_tone_reg;
                                    rest_len_next = cache_rest_reg;
                                    gate_next     = 1'b1;
                                end
                                if (sample_counter_reg >= tone_len_next)
                                begin
                                    gate_next = 1'b0;
                                    if (rest_len_next != '0)
                                    begin
                                        resting_next        = 1'b1;
                                        sample_counter_next = '0;
                                    end
                                    else
                                    begin
                                        advance = 1'b1;
                                    end
                                end
                            end
                            else if (sample_counter_reg >= rest_len_reg)
                            begin
                                advance = 1'b1;
                            end

                            if (advance)
                            begin
                                sample_counter_next = '0;
                                tone_len_next       = '0;
                                rest_len_next       = '0;
                                resting_next        = 1'b0;
                                note_pos_next       = pos_inc;
                                if (pos_inc >= note_total_reg)
                                begin
                                    if (loop_reg)
                                    begin
                                        note_pos_next = '0;
                                    end
                                    else
                                    begin
                                        finished_next = 1'b1;
                                        mode_next     = MODE_STOPPED;
                                    end
                                end
                            end
                        end
                        sounding = !finished_next && !resting_next;
                        if (sample_counter_next != LEN_MAX)
                        begin
                            sample_counter_next = sample_counter_next + LEN_W'(1);
                        end
                    end
                end
                OP_APPEND:
                begin
                    if (note_total_reg < POS_W'(NOTE_DEPTH))
                    begin
                        mem_we          = 1'b1;
                        note_total_next = note_total_reg + POS_W'(1);
                    end
                    else
                    begin
                        rejected = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    note_total_next     = '0;
                    note_pos_next       = '0;
                    sample_counter_next = '0;
                    tone_len_next       = '0;
                    rest_len_next       = '0;
                    resting_next        = 1'b0;
                    finished_next       = 1'b0;
                    gate_next           = 1'b0;
                end
                OP_PLAY:
                begin
                    if (note_total_reg != '0)
                    begin
                        mode_next = MODE_PLAYING;
                        if (finished_reg || !in_range_cur)
                        begin
                            note_pos_next       = '0;
                            sample_counter_next = '0;
                            tone_len_next       = '0;
                            rest_len_next       = '0;
                            resting_next        = 1'b0;
                            finished_next       = 1'b0;
                        end
                    end
                end
                OP_PAUSE:
                begin
                    mode_next = MODE_PAUSED;
                    gate_next = 1'b0;
                end
                OP_STOP:
                begin
                    mode_next           = MODE_STOPPED;
                    note_pos_next       = '0;
                    sample_counter_next = '0;
                    tone_len_next       = '0;
                    rest_len_next       = '0;
                    resting_next        = 1'b0;
                    finished_next       = 1'b0;
                    gate_next           = 1'b0;
                end
                OP_JUMP:
                begin
                    if (target_ext < total_ext)
                    begin
                        note_pos_next       = target_ext[POS_W-1:0];
                        sample_counter_next = '0;
                        tone_len_next       = '0;
                        rest_len_next       = '0;
                        resting_next        = 1'b0;
                        finished_next       = 1'b0;
                        mode_next           = MODE_PLAYING;
                    end
                    else
                    begin
                        rejected = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_range_new = note_pos_next < note_total_next;

    // cache goes stale when the position moves, its slot is rewritten or the rate is written
    assign inval = (cmd_accept && ((note_pos_next != note_pos_reg)
                    || (mem_we && note_total_reg == note_pos_reg)))
                   || (cfg_we && cfg_index == REG_RATE);
    assign fetch_issue = !cache_valid_reg && !fetch_busy_reg && !inval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_total_reg     <= '0;
            note_pos_reg       <= '0;
            sample_counter_reg <= '0;
            tone_len_reg       <= '0;
            rest_len_reg       <= '0;
            resting_reg        <= 1'b0;
            finished_reg       <= 1'b0;
            mode_reg           <= MODE_STOPPED;
            gate_reg           <= 1'b0;
            rate_reg           <= RATE_RESET;
            loop_reg           <= 1'b0;
        end
        else
        begin
            note_total_reg     <= note_total_next;
            note_pos_reg       <= note_pos_next;
            sample_counter_reg <= sample_counter_next;
            tone_len_reg       <= tone_len_next;
            rest_len_reg       <= rest_len_next;
            resting_reg        <= resting_next;
            finished_reg       <= finished_next;
            mode_reg           <= mode_next;
            gate_reg           <= gate_next;
            if (cfg_we && cfg_index == REG_RATE)
            begin
                rate_reg <= cfg_data[RATE_W-1:0];
            end
            if (cfg_we && cfg_index == REG_LOOP_ENABLE)
            begin
                loop_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            note_mem[note_total_reg[ADDR_W-1:0]] <= wr_entry;
        end
        if (fetch_issue)
        begin
            rd_data_reg <= note_mem[note_pos_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg <= 1'b0;
            fetch_busy_reg  <= 1'b0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= fetch_issue;
            if (inval)
            begin
                cache_valid_reg <= 1'b0;
                fetch_busy_reg  <= 1'b0;
            end
            else if (fetch_issue)
            begin
                fetch_busy_reg <= 1'b1;
            end
            else if (conv_valid)
            begin
                cache_valid_reg <= 1'b1;
                fetch_busy_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            cache_freq_reg <= rd_data_reg.freq;
            cache_vol_reg  <= rd_data_reg.vol;
        end
        if (conv_valid)
        begin
            cache_tone_reg <= conv_res.tone_len;
            cache_rest_reg <= conv_res.rest_len;
        end
    end

    assign conv_req.tone_ms = rd_data_reg.tone_ms;
    assign conv_req.rest_ms = rd_data_reg.rest_ms;

    nst_ms_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (inval),
        .in_valid  (rd_valid_reg),
        .req       (conv_req),
        .rate      (rate_reg),
        .out_valid (conv_valid),
        .res       (conv_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_move)
            begin
                c_valid_reg <= 1'b0;
            end
            if (c_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (stat.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            c_sounding_reg <= sounding;
            c_gate_reg     <= gate_next;
            c_pos_reg      <= note_pos_next;
            c_mode_reg     <= mode_next;
            c_done_reg     <= finished_next;
            c_rejected_reg <= rejected;
            c_in_range_reg <= in_range_new;
        end
        if (c_move)
        begin
            o_sounding_reg <= c_sounding_reg;
            o_gate_reg     <= c_gate_reg;
            o_freq_reg     <= c_in_range_reg ? cache_freq_reg : '0;
            o_vol_reg      <= c_in_range_reg ? cache_vol_reg : '0;
            o_pos_reg      <= c_pos_reg;
            o_mode_reg     <= c_mode_reg;
            o_done_reg     <= c_done_reg;
            o_rejected_reg <= c_rejected_reg;
        end
    end

    assign stat.valid       = o_valid_reg;
    assign stat.sounding    = o_sounding_reg;
    assign stat.gate        = o_gate_reg;
    assign stat.out_freq_hz = o_freq_reg;
    assign stat.out_volume  = o_vol_reg;
    assign stat.position    = POS_OUT_W'(o_pos_reg);
    assign stat.play_mode   = o_mode_reg;
    assign stat.done_res    = o_done_reg;
    assign stat.rejected    = o_rejected_reg;

    `NST_ASSERT_NOW(a_tick_needs_cache, clk, rst_n, cmd_accept && cmd.opcode == OP_TICK && in_range_cur, cache_valid_reg, "tick taken on a stale note cache")
    `NST_ASSERT_NOW(a_gate_not_resting, clk, rst_n, gate_reg, !resting_reg, "gate high during rest")
    `NST_ASSERT_NOW(a_rest_has_length, clk, rst_n, resting_reg, rest_len_reg != '0, "resting with zero rest length")
    `NST_ASSERT_NEXT(a_completion_lands, clk, rst_n, c_move, o_valid_reg, "completed transaction lost before output")

endmodule

`default_nettype wire
